// ===== rtl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg: shared definitions for the rational arithmetic reduce core
// command codes, result widths and the control structs between core and engine
// ----------------------------------------------------------------------------
`default_nettype none

package rar_pkg;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned NUM_W        = 33;
  localparam int unsigned DEN_W        = 32;
  localparam int unsigned OPERAND_W_DF = 16;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

  typedef struct packed {
    logic start;
    logic ack;
  } rar_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rar_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rar_engine.sv =====
// ----------------------------------------------------------------------------
// rar_engine: sequenced cross products, binary gcd and two restoring divides
// one multiplier and one shared subtract/compare unit under a small fsm
// ----------------------------------------------------------------------------
`default_nettype none

module rar_engine #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OPERAND_W_DF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rar_pkg::rar_ctl_t               ctl,
  input  wire logic [rar_pkg::CMD_W-1:0]       cmd,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
  output rar_pkg::rar_stat_t                   stat,
  output logic signed [rar_pkg::NUM_W-1:0]     res_num,
  output logic signed [rar_pkg::DEN_W-1:0]     res_den
);
  import rar_pkg::*;

  localparam int unsigned OW = OPERAND_WIDTH;
  localparam int unsigned RW = (2*OW + 1 > 64) ? 64 : 2*OW + 1;
  localparam int unsigned CW = $clog2(RW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FORM = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CMD_W-1:0]     cmd_r;
  logic signed [OW-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [RW-1:0] p0_r, p1_r, p2_r, p0_nxt, p1_nxt, p2_nxt;
  logic signed [RW-1:0] num_r, den_r, num_nxt, den_nxt;
  logic [RW-1:0]        mn_r, md_r, mn_nxt, md_nxt;
  logic [RW-1:0]        u_r, v_r, u_nxt, v_nxt;
  logic [RW-1:0]        g_r, g_nxt;
  logic [RW-1:0]        rem_r, rem_nxt, dq_r, dq_nxt, qn_r, qn_nxt;
  logic                 zero_r, zero_nxt;
  logic signed [NUM_W-1:0] rn_r, rn_nxt;
  logic signed [DEN_W-1:0] rd_r, rd_nxt;

  logic signed [OW-1:0]   mx, my;
  logic signed [2*OW-1:0] prod;
  logic signed [RW-1:0]   pext;
  logic [RW:0]            sub_a, sub_b;
  logic [RW+1:0]          diff;
  logic                   borrow;
  logic [RW-1:0]          dq_step;
  logic signed [RW:0]     sq_num, sq_den;

  // shared multiplier
  always_comb begin
    mx = an_r;
    my = bd_r;
    if (cnt_r == CW'(0)) begin
      mx = an_r;
      my = (cmd_r == CMD_MUL) ? bn_r : bd_r;
    end else if (cnt_r == CW'(1)) begin
      mx = ad_r;
      my = bn_r;
    end else begin
      mx = ad_r;
      my = (cmd_r == CMD_DIV) ? bn_r : bd_r;
    end
  end

  assign prod = mx * my;
  assign pext = RW'(prod);

  // shared subtract/compare unit
  always_comb begin
    if (state_r == S_GCD) begin
      sub_a = {1'b0, u_r};
      sub_b = {1'b0, v_r};
    end else begin
      sub_a = {rem_r, dq_r[RW-1]};
      sub_b = {1'b0, g_r};
    end
  end

  assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = diff[RW+1];
  assign dq_step = {dq_r[RW-2:0], ~borrow};

  always_comb begin
    sq_num = num_r[RW-1] ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});
    sq_den = den_r[RW-1] ? -$signed({1'b0, dq_step}) : $signed({1'b0, dq_step});
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    mn_nxt    = mn_r;
    md_nxt    = md_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    g_nxt     = g_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    qn_nxt    = qn_r;
    zero_nxt  = zero_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          state_nxt = S_MUL;
          cnt_nxt   = '0;
        end
      end
      S_MUL: begin
        if (cnt_r == CW'(0)) p0_nxt = pext;
        else if (cnt_r == CW'(1)) p1_nxt = pext;
        else p2_nxt = pext;
        if (cnt_r == CW'(2)) begin
          state_nxt = S_FORM;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_FORM: begin
        case (cmd_r)
          CMD_ADD: num_nxt = p0_r + p1_r;
          CMD_SUB: num_nxt = p0_r - p1_r;
          default: num_nxt = p0_r;
        endcase
        den_nxt   = p2_r;
        mn_nxt    = num_nxt[RW-1] ? RW'(-num_nxt) : RW'(num_nxt);
        md_nxt    = p2_r[RW-1] ? RW'(-p2_r) : RW'(p2_r);
        u_nxt     = mn_nxt;
        v_nxt     = md_nxt;
        k_nxt     = '0;
        zero_nxt  = 1'b0;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (u_r == '0 && v_r == '0) begin
          zero_nxt  = 1'b1;
          rn_nxt    = '0;
          rd_nxt    = '0;
          state_nxt = S_DONE;
        end else if (u_r == '0 || v_r == '0) begin
          g_nxt     = (u_r == '0) ? (v_r << k_r) : (u_r << k_r);
          rem_nxt   = '0;
          dq_nxt    = mn_r;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + CW'(1);
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (borrow) begin
          u_nxt = v_r;
          v_nxt = u_r;
        end else begin
          u_nxt = diff[RW-1:0];
        end
      end
      S_DIVN, S_DIVD: begin
        rem_nxt = borrow ? sub_a[RW-1:0] : diff[RW-1:0];
        dq_nxt  = dq_step;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(RW - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          if (state_r == S_DIVN) begin
            qn_nxt    = dq_step;
            dq_nxt    = md_r;
            state_nxt = S_DIVD;
          end else begin
            rn_nxt    = NUM_W'(sq_num);
            rd_nxt    = DEN_W'(sq_den);
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (ctl.ack) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && ctl.start) begin
      cmd_r <= cmd;
      an_r  <= a_num;
      ad_r  <= a_den;
      bn_r  <= b_num;
      bd_r  <= b_den;
    end
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    mn_r  <= mn_nxt;
    md_r  <= md_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    g_r   <= g_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    qn_r  <= qn_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign stat.zero = zero_r;
  assign res_num   = rn_r;
  assign res_den   = rd_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVN || state_r == S_DIVD) |-> (g_r != '0))
    else $error("divide by zero gcd");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r < CW'(3)))
    else $error("product count overrun");

  a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && ctl.start) |=> (state_r == S_MUL))
    else $error("start not taken");

endmodule

`default_nettype wire

// ===== rtl/rational_arith_reduce_core.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_core: fraction add/sub/mul/div with gcd reduction
// stream front end with a result register around the sequenced engine
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low bit up)                     tuser
//  in       in   command, a_num, a_den, b_num, b_den, pad      -
//  out      out  result_num, result_den, pad                   zero_gcd
//
//  one transaction runs the three cross products, a form step, the binary gcd loop and
//  two restoring divides of RW quotient bits each, then a done state;
//  RW = 2*OPERAND_WIDTH+1 (max 64); the gcd loop and the two restoring divides
//  share the one subtractor
//  in_tready is low while the engine works; a finished result waits in the engine
//  while the output register is still full, and in_tready stays low until it moves
//  reset is synchronous, active low, and empties the result register
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_reduce_core #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OPERAND_W_DF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  // command, a_num, a_den, b_num, b_den, zero pad
  input  wire logic [((2+4*OPERAND_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  // result_num, result_den, zero pad
  output logic [((rar_pkg::NUM_W+rar_pkg::DEN_W+7)/8)*8-1:0] out_tdata,
  // zero_gcd
  output logic [0:0]                                     out_tuser
);
  import rar_pkg::*;

  localparam int unsigned OW    = OPERAND_WIDTH;
  localparam int unsigned OUT_W = ((NUM_W + DEN_W + 7) / 8) * 8;

  rar_ctl_t  ctl;
  rar_stat_t stat;
  logic signed [NUM_W-1:0] res_num;
  logic signed [DEN_W-1:0] res_den;
  logic                    load;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_zero_r;

  assign in_tready = !stat.busy;
  assign load      = stat.done && (!out_valid_r || out_tready);
  assign ctl.start = in_tvalid && in_tready;
  assign ctl.ack   = load;

  rar_engine #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cmd    (in_tdata[CMD_W-1:0]),
    .a_num  ($signed(in_tdata[CMD_W+OW-1:CMD_W])),
    .a_den  ($signed(in_tdata[CMD_W+2*OW-1:CMD_W+OW])),
    .b_num  ($signed(in_tdata[CMD_W+3*OW-1:CMD_W+2*OW])),
    .b_den  ($signed(in_tdata[CMD_W+4*OW-1:CMD_W+3*OW])),
    .stat   (stat),
    .res_num(res_num),
    .res_den(res_den)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= OUT_W'({res_den, res_num});
      out_zero_r <= stat.zero;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_zero_r;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction taken while busy");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("zero gcd flag with nonzero result");

  a_load_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid) && $past(rst_n)) |-> $past(stat.done))
    else $error("result without engine completion");

endmodule

`default_nettype wire

// ===== tb/rational_arith_reduce_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_core_tb: self-checking bench for fraction arithmetic
// drives add/sub/mul/div transactions with bursty input and a stalling sink,
// predicts the reduced numerator/denominator and compares every result in order
// ----------------------------------------------------------------------------

module rational_arith_reduce_core_tb;
  import rar_pkg::*;

  localparam int unsigned OW     = OPERAND_W_DF;
  localparam int unsigned IN_W   = ((2+4*OW+7)/8)*8;
  localparam int unsigned OUT_W  = ((NUM_W+DEN_W+7)/8)*8;
  localparam int          NRAND  = 1800;
  localparam int          IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             zero;
  } fraction_t;

  class fraction_scoreboard;
    fraction_t pending[$];
    int        errors;

    function automatic logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
      logic [63:0] r;
      while (v != 0) begin
        r = u % v;
        u = v;
        v = r;
      end
      return u;
    endfunction

    function automatic logic [63:0] shrink(logic [63:0] raw, logic [63:0] g);
      logic [63:0] q;
      q = mag(raw) / g;
      return raw[63] ? -q : q;
    endfunction

    function void note_input(logic [IN_W-1:0] d);
      logic [CMD_W-1:0] op;
      logic [63:0] an, ad, bn, bd, n, dn, g;
      fraction_t f;
      op = d[1:0];
      an = 64'(signed'(d[2+OW-1 -: OW]));
      ad = 64'(signed'(d[2+2*OW-1 -: OW]));
      bn = 64'(signed'(d[2+3*OW-1 -: OW]));
      bd = 64'(signed'(d[2+4*OW-1 -: OW]));
      case (op)
        CMD_ADD: begin n = an*bd + ad*bn; dn = ad*bd; end
        CMD_SUB: begin n = an*bd - ad*bn; dn = ad*bd; end
        CMD_MUL: begin n = an*bn; dn = ad*bd; end
        default: begin n = an*bd; dn = ad*bn; end
      endcase
      g = gcd64(mag(n), mag(dn));
      if (g == 0) begin
        f.num = '0; f.den = '0; f.zero = 1'b1;
      end else begin
        f.num = NUM_W'(shrink(n, g));
        f.den = DEN_W'(shrink(dn, g));
        f.zero = 1'b0;
      end
      pending.push_back(f);
    endfunction

    function void check_result(logic [OUT_W-1:0] d, logic z);
      fraction_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result num=%h den=%h", $realtime, d[NUM_W-1:0],
                 d[NUM_W+DEN_W-1:NUM_W]);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[NUM_W-1:0] !== e.num) begin
        $display("%0t: result_num expected %h actual %h", $realtime, e.num, d[NUM_W-1:0]);
        errors++;
      end
      if (d[NUM_W+DEN_W-1:NUM_W] !== e.den) begin
        $display("%0t: result_den expected %h actual %h", $realtime, e.den,
                 d[NUM_W+DEN_W-1:NUM_W]);
        errors++;
      end
      if (z !== e.zero) begin
        $display("%0t: zero_gcd expected %b actual %b", $realtime, e.zero, z);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [0:0]       out_tuser;

  fraction_scoreboard sb;
  bit  hold_sink;
  int  idle_cycles = 0;

  rational_arith_reduce_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [OW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(OW-1){1'b0}}};
      1: return {1'b0, {(OW-1){1'b1}}};
      2: return '0;
      3: return OW'($urandom_range(0, 2)) - OW'(1);
      4, 5: return OW'($urandom_range(0, 40)) - OW'(20);
      default: return OW'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_item(logic [CMD_W-1:0] op, logic [OW-1:0] an,
                                                logic [OW-1:0] ad, logic [OW-1:0] bn,
                                                logic [OW-1:0] bd);
    logic [IN_W-1:0] d;
    d = '0;
    d[2+4*OW-1:0] = {bd, bn, ad, an, op};
    return d;
  endfunction

  task automatic send_item(logic [IN_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_input(d);
  endtask

  task automatic drop_valid(int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'({$urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  // sink stall pattern, with one long hold-off near the start
  initial begin
    int phase;
    out_tready <= 1'b0;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      phase++;
      if (hold_sink) out_tready <= 1'b0;
      else if (phase % 2000 < 700) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [OW-1:0] mn, mx;
    int n, burst;
    sb = new();
    mn = {1'b1, {(OW-1){1'b0}}};
    mx = {1'b0, {(OW-1){1'b1}}};
    hold_sink = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // long sink hold-off while the source keeps offering
    hold_sink = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        send_item(pack_item(CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3));
        send_item(pack_item(CMD_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2));
        send_item(pack_item(CMD_MUL, mn, mn, mn, mn));
        send_item(pack_item(CMD_DIV, mx, mn, mn, mx));
      end
    join
    send_item(pack_item(CMD_ADD, mn, mx, mn, mx));
    send_item(pack_item(CMD_SUB, mn, mx, mx, mn));
    send_item(pack_item(CMD_MUL, mx, mx, mx, mx));
    send_item(pack_item(CMD_ADD, '0, '0, '0, '0));
    send_item(pack_item(CMD_SUB, '0, '0, '0, '0));
    send_item(pack_item(CMD_MUL, '0, '0, 16'sd5, 16'sd7));
    send_item(pack_item(CMD_DIV, '0, '0, '0, '0));
    send_item(pack_item(CMD_MUL, '0, 16'sd3, 16'sd4, 16'sd5));
    send_item(pack_item(CMD_MUL, 16'sd3, -16'sd4, 16'sd4, 16'sd6));
    send_item(pack_item(CMD_DIV, 16'sd3, 16'sd4, '0, 16'sd5));
    send_item(pack_item(CMD_MUL, 16'sd3, '0, 16'sd4, 16'sd5));
    send_item(pack_item(CMD_DIV, -16'sd3, 16'sd4, '0, 16'sd5));
    send_item(pack_item(CMD_ADD, 16'sd1, 16'sd1, -16'sd1, 16'sd1));
    send_item(pack_item(CMD_DIV, 16'sd6, -16'sd9, 16'sd4, 16'sd3));
    send_item(pack_item(CMD_SUB, mx, 16'sd1, mn, 16'sd1));
    send_item(pack_item(CMD_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1));
    drop_valid(3);

    n = 0;
    while (n < NRAND) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      repeat (burst) begin
        send_item(pack_item(CMD_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                            pick_operand(), pick_operand()));
        n++;
      end
      drop_valid($urandom_range(0, 1) ? $urandom_range(1, 300) : 0);
    end
    drop_valid(1);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rar_pkg.sv
rtl/rar_engine.sv
rtl/rational_arith_reduce_core.sv
tb/rational_arith_reduce_core_tb.sv
